>>> sv/prq_pkg.sv
`timescale 1ns / 1ps

package prq_pkg;

  localparam int unsigned LEVELS  = 32;
  localparam int unsigned THREADS = 16;

  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned TID_W  = $clog2(THREADS);
  // thread slot: a thread id or the "none" marker
  localparam int unsigned SLOT_W = $clog2(THREADS + 1);

  localparam logic [SLOT_W-1:0] NONE       = SLOT_W'(THREADS);
  localparam logic [LVL_W-1:0]  IDLE_LEVEL = LVL_W'(LEVELS - 1);

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_SCHEDULE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_ALREADY   = 2'd2,
    STATUS_NOT_READY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [TID_W-1:0] thread_id;
    logic [4:0]       thread_priority;
  } in_item_t;

  typedef struct packed {
    logic              switched;
    logic [4:0]        old_thread;
    logic [4:0]        run_thread;
    logic [4:0]        running_priority;
    logic [LEVELS-1:0] ready_levels;
    logic [1:0]        status;
  } out_item_t;

endpackage

>>> sv/prq_if.sv
`timescale 1ns / 1ps

interface prq_in_if;
  logic               valid;
  logic               ready;
  prq_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prq_out_if;
  logic               valid;
  logic               ready;
  prq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// Path: an accepted item waits in the input register (s1); the queue
//   update then writes the new state and the result register together.
// Throughput: one item per cycle unless the result side stalls; the list
//   update and the lowest-set-bit encoder over the level bitmap both fit
//   between the two registers.
// Reset (async, active low): no levels ready, all heads/tails empty, no thread
//   current, current level idle; link and level stores stay undefined.
module priority_ready_queue_scheduler (
  input  logic         clk_i,
  input  logic         rst_ni,
  prq_in_if.sink       in_i,
  prq_out_if.source    out_o
);

  localparam int unsigned LEVELS  = prq_pkg::LEVELS;
  localparam int unsigned THREADS = prq_pkg::THREADS;
  localparam int unsigned LVL_W   = prq_pkg::LVL_W;
  localparam int unsigned TID_W   = prq_pkg::TID_W;
  localparam int unsigned SLOT_W  = prq_pkg::SLOT_W;

  // ---------------------------------------------------------------------------
  // Handshake: input register (s1) feeds the result register (out).
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  prq_pkg::in_item_t  s1_item_q;
  logic               out_valid_q;
  prq_pkg::out_item_t out_item_q;
  logic               advance;
  logic               fire;

  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = s1_valid_q && advance;
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Scheduler state
  // ---------------------------------------------------------------------------
  logic [LEVELS-1:0]  bitmap_q, bitmap_d;
  logic [SLOT_W-1:0]  head_q [LEVELS];
  logic [SLOT_W-1:0]  tail_q [LEVELS];
  logic [SLOT_W-1:0]  next_q [THREADS];
  logic [SLOT_W-1:0]  next_d [THREADS];
  logic [SLOT_W-1:0]  prev_q [THREADS];
  logic [SLOT_W-1:0]  prev_d [THREADS];
  logic [LVL_W-1:0]   tlevel_q [THREADS];
  logic [THREADS-1:0] ready_q, ready_d;
  logic [SLOT_W-1:0]  cur_q, cur_d;
  logic [LVL_W-1:0]   curlvl_q, curlvl_d;

  // head/tail write port: one level per item
  logic               ht_we;
  logic [SLOT_W-1:0]  head_wdata;
  logic [SLOT_W-1:0]  tail_wdata;
  logic               tlevel_we;

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic [TID_W-1:0]   tid;
  logic [LVL_W-1:0]   pri;
  logic [LVL_W-1:0]   enc_lvl;
  logic [LVL_W-1:0]   lvl_sel;
  logic [SLOT_W-1:0]  head_rd;
  logic [SLOT_W-1:0]  tail_rd;
  logic [SLOT_W-1:0]  p_link;
  logic [SLOT_W-1:0]  n_link;
  logic [SLOT_W-1:0]  new_head;
  logic [SLOT_W-1:0]  new_tail;
  logic               switched;
  logic [SLOT_W-1:0]  from_thr;
  prq_pkg::status_e   status;

  assign tid = s1_item_q.thread_id;
  // priorities beyond the last level saturate to it
  assign pri = (32'(s1_item_q.thread_priority) >= LEVELS) ? prq_pkg::IDLE_LEVEL
                                                          : LVL_W'(s1_item_q.thread_priority);

  // lowest set bit = highest ready priority
  always_comb begin
    enc_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (bitmap_q[i]) begin
        enc_lvl = LVL_W'(i);
      end
    end
  end

  // single level address per item
  always_comb begin
    case (s1_item_q.func)
      prq_pkg::FUNC_INSERT: lvl_sel = pri;
      prq_pkg::FUNC_REMOVE: lvl_sel = tlevel_q[tid];
      default:              lvl_sel = enc_lvl;
    endcase
  end

  assign head_rd = head_q[lvl_sel];
  assign tail_rd = tail_q[lvl_sel];
  assign p_link  = prev_q[tid];
  assign n_link  = next_q[tid];
  // unlink: predecessor/successor take over the end slots
  assign new_head = (p_link == prq_pkg::NONE) ? n_link : head_rd;
  assign new_tail = (n_link == prq_pkg::NONE) ? p_link : tail_rd;

  always_comb begin
    bitmap_d   = bitmap_q;
    next_d     = next_q;
    prev_d     = prev_q;
    ready_d    = ready_q;
    cur_d      = cur_q;
    curlvl_d   = curlvl_q;
    ht_we      = 1'b0;
    head_wdata = head_rd;
    tail_wdata = tail_rd;
    tlevel_we  = 1'b0;
    switched   = 1'b0;
    from_thr   = prq_pkg::NONE;
    status     = prq_pkg::STATUS_OK;

    case (s1_item_q.func)
      prq_pkg::FUNC_INSERT: begin
        if (ready_q[tid]) begin
          status = prq_pkg::STATUS_ALREADY;
        end else begin
          prev_d[tid] = tail_rd;
          next_d[tid] = prq_pkg::NONE;
          ht_we       = 1'b1;
          tail_wdata  = SLOT_W'(tid);
          if (tail_rd == prq_pkg::NONE) begin
            head_wdata = SLOT_W'(tid);
          end else begin
            next_d[tail_rd[TID_W-1:0]] = SLOT_W'(tid);
          end
          tlevel_we         = 1'b1;
          ready_d[tid]      = 1'b1;
          bitmap_d[lvl_sel] = 1'b1;
        end
      end
      prq_pkg::FUNC_REMOVE: begin
        if (!ready_q[tid]) begin
          status = prq_pkg::STATUS_NOT_READY;
        end else begin
          if (p_link != prq_pkg::NONE) begin
            next_d[p_link[TID_W-1:0]] = n_link;
          end
          if (n_link != prq_pkg::NONE) begin
            prev_d[n_link[TID_W-1:0]] = p_link;
          end
          ht_we        = 1'b1;
          head_wdata   = new_head;
          tail_wdata   = new_tail;
          ready_d[tid] = 1'b0;
          if (new_head == prq_pkg::NONE) begin
            bitmap_d[lvl_sel] = 1'b0;
          end
        end
      end
      prq_pkg::FUNC_SCHEDULE: begin
        if (bitmap_q == '0) begin
          status = prq_pkg::STATUS_EMPTY;
        end else if (head_rd != prq_pkg::NONE && head_rd != cur_q) begin
          switched = 1'b1;
          from_thr = cur_q;
          cur_d    = head_rd;
          curlvl_d = lvl_sel;
        end
      end
      default: begin
        // unused code: item passes with no change
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q <= '0;
      ready_q  <= '0;
      cur_q    <= prq_pkg::NONE;
      curlvl_q <= prq_pkg::IDLE_LEVEL;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= prq_pkg::NONE;
        tail_q[i] <= prq_pkg::NONE;
      end
    end else if (fire) begin
      bitmap_q <= bitmap_d;
      ready_q  <= ready_d;
      cur_q    <= cur_d;
      curlvl_q <= curlvl_d;
      if (ht_we) begin
        head_q[lvl_sel] <= head_wdata;
        tail_q[lvl_sel] <= tail_wdata;
      end
    end
  end

  // links and levels are only read for ready threads, which wrote them
  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_q <= next_d;
      prev_q <= prev_d;
      if (tlevel_we) begin
        tlevel_q[tid] <= lvl_sel;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q.switched         <= switched;
      out_item_q.old_thread       <= 5'(from_thr);
      out_item_q.run_thread       <= 5'(cur_d);
      out_item_q.running_priority <= 5'(curlvl_d);
      out_item_q.ready_levels     <= bitmap_d;
      out_item_q.status           <= status;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [LEVELS-1:0] head_busy;
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      head_busy[i] = (head_q[i] != prq_pkg::NONE);
    end
  end

  // bitmap bit set exactly when the level list is non-empty
  a_bitmap_tracks_heads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitmap_q == head_busy)
    else $error("level bitmap out of step with list heads");

  // a switch always moves to a different thread
  a_switch_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.switched |->
      out_item_q.run_thread != out_item_q.old_thread &&
      out_item_q.status == prq_pkg::STATUS_OK)
    else $error("switch reported to the same thread");

  // nothing-ready status only with an empty bitmap
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.status == prq_pkg::STATUS_EMPTY |->
      out_item_q.ready_levels == '0)
    else $error("nothing-ready reported with levels ready");

  // a successful remove clears the thread's ready flag
  a_remove_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_item_q.func == prq_pkg::FUNC_REMOVE && ready_q[tid] |=>
      !ready_q[$past(tid)])
    else $error("removed thread still ready");

endmodule

>>> verif/prq_sched_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own ready-queue state and checks every
// result against the oldest outstanding prediction.
module prq_sched_checker (
  input  logic clk_i,
  input  logic rst_ni,
  prq_in_if    in_mon_i,
  prq_out_if   out_mon_i,
  output int   fail_count_o,
  output int   outstanding_o
);
  import prq_pkg::*;

  // predicted scheduler state
  logic [LEVELS-1:0]  lvl_bits;
  logic [SLOT_W-1:0]  lvl_head [LEVELS];
  logic [SLOT_W-1:0]  lvl_tail [LEVELS];
  logic [SLOT_W-1:0]  nxt      [THREADS];
  logic [SLOT_W-1:0]  prv      [THREADS];
  logic [LVL_W-1:0]   lvl_of   [THREADS];
  logic [THREADS-1:0] is_ready;
  logic [SLOT_W-1:0]  running;
  logic [LVL_W-1:0]   running_lvl;

  out_item_t sched_reports_q[$];
  out_item_t want_rep;
  out_item_t new_rep;
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic clear_ready_queue();
    lvl_bits = '0;
    is_ready = '0;
    running = NONE;
    running_lvl = IDLE_LEVEL;
    for (int i = 0; i < LEVELS; i++) begin
      lvl_head[i] = NONE;
      lvl_tail[i] = NONE;
    end
  endtask

  // one operation against the predicted state; returns the report it causes
  task automatic step_ready_queue(input in_item_t op, output out_item_t rep);
    logic [TID_W-1:0]  tid;
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    logic [SLOT_W-1:0] hd;
    logic [LVL_W-1:0]  lv;
    int                sel;
    rep = '0;
    rep.old_thread = NONE;
    rep.status = STATUS_OK;
    tid = op.thread_id;
    lv = (op.thread_priority >= LEVELS) ? IDLE_LEVEL : LVL_W'(op.thread_priority);
    case (op.func)
      FUNC_INSERT: begin
        if (is_ready[tid]) begin
          rep.status = STATUS_ALREADY;
        end else begin
          p = lvl_tail[lv];
          prv[tid] = p;
          nxt[tid] = NONE;
          if (p == NONE) lvl_head[lv] = SLOT_W'(tid);
          else nxt[p[TID_W-1:0]] = SLOT_W'(tid);
          lvl_tail[lv] = SLOT_W'(tid);
          lvl_of[tid] = lv;
          is_ready[tid] = 1'b1;
          lvl_bits[lv] = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (!is_ready[tid]) begin
          rep.status = STATUS_NOT_READY;
        end else begin
          lv = lvl_of[tid];
          p = prv[tid];
          n = nxt[tid];
          if (p == NONE) lvl_head[lv] = n;
          else nxt[p[TID_W-1:0]] = n;
          if (n == NONE) lvl_tail[lv] = p;
          else prv[n[TID_W-1:0]] = p;
          is_ready[tid] = 1'b0;
          if (lvl_head[lv] == NONE) lvl_bits[lv] = 1'b0;
        end
      end
      FUNC_SCHEDULE: begin
        sel = -1;
        for (int i = LEVELS - 1; i >= 0; i--) if (lvl_bits[i]) sel = i;
        if (sel < 0) begin
          rep.status = STATUS_EMPTY;
        end else begin
          hd = lvl_head[sel];
          if (hd != NONE && hd != running) begin
            rep.switched = 1'b1;
            rep.old_thread = running;
            running = hd;
            running_lvl = LVL_W'(sel);
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
    rep.run_thread = running;
    rep.running_priority = running_lvl;
    rep.ready_levels = lvl_bits;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v,
               act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_ready_queue();
      sched_reports_q.delete();
      outstanding_o <= 0;
    end else begin
      // results first: a report can never belong to an item taken this edge
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (sched_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $realtime,
                   out_mon_i.data);
        end else begin
          want_rep = sched_reports_q.pop_front();
          check_field("switched", 32'(want_rep.switched), 32'(out_mon_i.data.switched));
          check_field("old_thread", 32'(want_rep.old_thread),
                      32'(out_mon_i.data.old_thread));
          check_field("run_thread", 32'(want_rep.run_thread),
                      32'(out_mon_i.data.run_thread));
          check_field("running_priority", 32'(want_rep.running_priority),
                      32'(out_mon_i.data.running_priority));
          check_field("ready_levels", 32'(want_rep.ready_levels),
                      32'(out_mon_i.data.ready_levels));
          check_field("status", 32'(want_rep.status), 32'(out_mon_i.data.status));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        step_ready_queue(in_mon_i.data, new_rep);
        sched_reports_q.push_back(new_rep);
      end
      outstanding_o <= sched_reports_q.size();
    end
  end

endmodule

>>> verif/tb_priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps

// Top of the scheduler bench. Drives operations into the block, paces the
// result side, and gives the verdict. All prediction and comparison sits in
// prq_sched_checker.
module tb_priority_ready_queue_scheduler;
  import prq_pkg::*;

  // code 3 is not an operation; the block must ignore it
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 200;   // long receiver stall
  localparam int IDLE_LIMIT    = 3000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 20;    // settle time after the final drain

  logic clk_i = 1'b0;
  logic rst_ni;

  prq_in_if  in_ch ();
  prq_out_if out_ch ();

  int fail_count;
  int outstanding;

  // pacing knobs
  bit tx_burst = 1'b0;   // sender: no gaps while set
  bit rx_burst = 1'b0;   // receiver: no stalls while set
  bit hold_req = 1'b0;   // ask the receiver for one long stall

  // which threads the stimulus believes are queued; only used to bias
  // the random ops toward legal inserts/removes
  bit [THREADS-1:0] queued_shadow = '0;

  int idle_cycles = 0;

  priority_ready_queue_scheduler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  prq_sched_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_ch),
    .out_mon_i     (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: any item moving on either channel resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender side. Leaves valid high across back-to-back items so that it is
  // never dropped and raised in the same step.
  task automatic push_item(input in_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic issue(input logic [1:0] f, input int tid, input int pri);
    in_item_t it;
    it.func            = f;
    it.thread_id       = TID_W'(tid);
    it.thread_priority = 5'(pri);
    if (f == FUNC_INSERT) queued_shadow[tid] = 1'b1;
    else if (f == FUNC_REMOVE) queued_shadow[tid] = 1'b0;
    push_item(it);
  endtask

  // Stop sending and wait for every outstanding report. The first edge lets
  // the checker count the item taken at the last acceptance.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // random thread that is (want_queued=1) or is not queued; -1 if none
  function automatic int pick_thread(input bit want_queued);
    int start;
    int t;
    start = $urandom_range(0, THREADS - 1);
    for (int k = 0; k < THREADS; k++) begin
      t = (start + k) % THREADS;
      if (queued_shadow[t] == want_queued) return t;
    end
    return -1;
  endfunction

  task automatic random_op();
    int roll;
    int tid;
    int pri;
    roll = $urandom_range(0, 99);
    // mostly a handful of levels so FIFOs get several entries deep
    if ($urandom_range(0, 3) == 0) begin
      pri = $urandom_range(0, 31);
    end else begin
      case ($urandom_range(0, 3))
        0:       pri = 0;
        1:       pri = 1;
        2:       pri = 7;
        default: pri = 30;
      endcase
    end
    tid = -1;
    if (roll < 40) begin
      tid = pick_thread(1'b0);
      if (tid >= 0) issue(FUNC_INSERT, tid, pri);
    end else if (roll < 65) begin
      tid = pick_thread(1'b1);
      if (tid >= 0) issue(FUNC_REMOVE, tid, $urandom_range(0, 31));
    end else if (roll >= 90) begin
      // noise: any code, any thread -> double inserts, stray removes, code 3
      tid = $urandom_range(0, THREADS - 1);
      issue(2'($urandom_range(0, 3)), tid, $urandom_range(0, 31));
    end
    // schedules, plus the fallback when no suitable thread was found
    if (tid < 0)
      issue(FUNC_SCHEDULE, $urandom_range(0, THREADS - 1), $urandom_range(0, 31));
  endtask

  // Receiver side: own process, own gap per item, one long hold on request.
  initial begin : rx_side
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 8);
      end
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    issue(FUNC_SCHEDULE, 0, 0);     // nothing ready
    issue(FUNC_REMOVE, 5, 0);       // thread not queued
    issue(FUNC_INSERT, 0, 31);      // lowest level
    issue(FUNC_INSERT, 15, 0);      // highest level
    issue(FUNC_INSERT, 3, 0);       // second in the level-0 FIFO
    issue(FUNC_INSERT, 15, 4);      // double insert
    issue(FUNC_INSERT, 7, 16);
    issue(FUNC_SCHEDULE, 9, 31);    // switch from none to 15
    issue(FUNC_SCHEDULE, 0, 0);     // head is already current
    issue(FUNC_REMOVE, 15, 31);     // head removal, 3 moves up
    issue(FUNC_SCHEDULE, 15, 31);   // switch 15 -> 3
    issue(FUNC_REMOVE, 3, 0);       // level 0 empties
    issue(FUNC_SCHEDULE, 0, 0);     // switch to 7 at level 16
    issue(FUNC_INSERT, 9, 16);
    issue(FUNC_INSERT, 10, 16);
    issue(FUNC_REMOVE, 9, 0);       // middle of a list
    issue(FUNC_REMOVE, 10, 0);      // tail of a list
    issue(FUNC_RESERVED, 15, 31);   // ignored code
    issue(FUNC_REMOVE, 7, 0);
    issue(FUNC_SCHEDULE, 0, 0);     // down to the idle level, thread 0
    issue(FUNC_REMOVE, 0, 0);       // bitmap back to zero
    issue(FUNC_SCHEDULE, 0, 0);     // nothing ready again
    drain();

    // --- random part ---
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      // back pressure: receiver stalls long while the sender streams
      if (i == 300) begin
        hold_req = 1'b1;
        tx_burst = 1'b1;
      end
      // sender pause until everything is back
      if (i == 550) drain();
      random_op();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/prq_pkg.sv
sv/prq_if.sv
sv/priority_ready_queue_scheduler.sv
verif/prq_sched_checker.sv
verif/tb_priority_ready_queue_scheduler.sv
